// ===== rtl/sam_pkg.sv =====
// Package: constants, tables and helpers of the sprite affine matrix builder.
`default_nettype none
package sam_pkg;

  localparam int CordicStagesDef = 16;
  localparam int TableLen        = 24;

  localparam logic [14:0] TurnUnits    = 15'd23040;
  localparam logic [14:0] HalfUnits    = 15'd11520;
  localparam logic [14:0] QuarterUnits = 15'd5760;

  // pi * 2^30
  localparam logic [31:0] PiQ30   = 32'd3373259426;
  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  // Angle to radians: t*pi*2^30/11520 splits into t*RadK plus
  // (t*RadR + 5760)/11520. The second quotient drops the 2^8 factor of 11520
  // by a shift and divides by the odd rest (45) with a reciprocal multiply,
  // exact for every dividend the angle range can produce.
  localparam logic [18:0] RadK = 19'(PiQ30 / 32'(HalfUnits));
  localparam logic [12:0] RadR = 13'(PiQ30 % 32'(HalfUnits));
  localparam int RadShift   = 8;
  localparam int RecipShift = 24;
  localparam logic [18:0] RecipOdd =
    19'(((64'd1 << RecipShift) + 64'(HalfUnits >> RadShift) - 64'd1) /
        64'(HalfUnits >> RadShift));

  // Angles carry 2^30*atan(2^-i)
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    begin
      case (i)
        5'd0:  v = 30'd843314856;
        5'd1:  v = 30'd497837829;
        5'd2:  v = 30'd263043837;
        5'd3:  v = 30'd133525158;
        5'd4:  v = 30'd67021687;
        5'd5:  v = 30'd33543516;
        5'd6:  v = 30'd16775851;
        5'd7:  v = 30'd8388437;
        5'd8:  v = 30'd4194282;
        5'd9:  v = 30'd2097149;
        5'd10: v = 30'd1048575;
        5'd11: v = 30'd524287;
        5'd12: v = 30'd262143;
        5'd13: v = 30'd131071;
        5'd14: v = 30'd65535;
        5'd15: v = 30'd32767;
        5'd16: v = 30'd16383;
        5'd17: v = 30'd8191;
        5'd18: v = 30'd4095;
        5'd19: v = 30'd2047;
        5'd20: v = 30'd1023;
        5'd21: v = 30'd511;
        5'd22: v = 30'd255;
        5'd23: v = 30'd127;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

  // Saturate a signed 64-bit value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sprite_affine_matrix_builder.sv =====
// Top level: sprite affine matrix builder pipeline.
//
// Usage: present one sprite request per cycle on the in_ channel (position,
// origin, scale, rotation); each accepted request yields one result on the
// out_ channel holding m00, m01, m02, m10, m11, m12 in signed Q16.16.
// Throughput: one request per cycle while out_stall does not hold the pipe.
// Depth: CORDIC_STAGES + 10 register stages (CORDIC stage count capped at 24).
// The depth is set by the angle reduction stages, one stage per CORDIC
// iteration, then the multiply, round and translation stages.
// The whole pipeline advances as one: when out_stall is high and the last
// stage holds a result, every stage holds and in_stall is raised. Bubbles
// inside the pipe are not squeezed out; only an empty output register lets
// the pipe move while the receiver stalls.
// Reset (rst_n low, synchronous) clears every stage valid bit; payloads
// are not reset. No configuration, no state between requests.
// Pipeline: A reduce mod 360, B fold to +-90, C/D angle to radians,
// CORDIC stages, E clamp/flip, F scale multiply, G round, H origin
// products, I sum and round, J saturate into the output register.
`default_nettype none
module sprite_affine_matrix_builder
  import sam_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [31:0] in_pos_x,
  input  wire signed [31:0] in_pos_y,
  input  wire signed [31:0] in_origin_x,
  input  wire signed [31:0] in_origin_y,
  input  wire signed [15:0] in_scale_x,
  input  wire signed [15:0] in_scale_y,
  input  wire signed [15:0] in_rotation_deg,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] out_m00,
  output logic signed [31:0] out_m01,
  output logic signed [31:0] out_m02,
  output logic signed [31:0] out_m10,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12
);
  localparam int NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  // Payload carried through the CORDIC: pos, origin, scale, flip.
  localparam int PW = 32 * 4 + 16 * 2 + 1;

  // One global advance: the pipe moves unless the output holds a result
  // that the receiver stalls.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: reduce mod 360 degrees (23040 units). Operand range is small,
  // so fold with three compare-add/subtract steps on the signed value.
  logic        a_v_r;
  logic [14:0] a_r_r;
  logic [31:0] a_px_r, a_py_r, a_ox_r, a_oy_r;
  logic [15:0] a_sx_r, a_sy_r;
  logic [14:0] a_rnxt;
  logic signed [17:0] a_t;

  always_comb begin
    a_t = 18'(in_rotation_deg);
    if (a_t < 0) a_t = a_t + 18'sd23040;
    if (a_t < 0) a_t = a_t + 18'sd23040;
    if (a_t >= 18'sd23040) a_t = a_t - 18'sd23040;
    a_rnxt = a_t[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r_r <= a_rnxt;
      a_px_r <= in_pos_x;  a_py_r <= in_pos_y;
      a_ox_r <= in_origin_x; a_oy_r <= in_origin_y;
      a_sx_r <= in_scale_x;  a_sy_r <= in_scale_y;
    end
  end

  // Stage B: negate, bring into [-180,180), then fold to [-90,90].
  logic        b_v_r, b_flip_r, b_neg_r;
  logic [12:0] b_mag_r;
  logic [PW-2:0] b_p_r;
  logic signed [16:0] b_t;
  logic        b_flip;

  always_comb begin
    b_t = -$signed({2'b00, a_r_r});
    b_flip = 1'b0;
    if (b_t < -$signed({2'b00, HalfUnits})) b_t = b_t + $signed({2'b00, TurnUnits});
    if (b_t > $signed({2'b00, QuarterUnits})) begin
      b_t = b_t - $signed({2'b00, HalfUnits});
      b_flip = 1'b1;
    end else if (b_t < -$signed({2'b00, QuarterUnits})) begin
      b_t = b_t + $signed({2'b00, HalfUnits});
      b_flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_flip_r <= b_flip;
      b_neg_r  <= b_t[16];
      b_mag_r  <= b_t[16] ? 13'(-b_t) : b_t[12:0];
      b_p_r    <= {a_px_r, a_py_r, a_ox_r, a_oy_r, a_sx_r, a_sy_r};
    end
  end

  // Stage C: whole part of magnitude*pi/11520 and the remainder term that
  // still needs dividing (with its rounding constant).
  logic        c_v_r, c_neg_r;
  logic [31:0] c_hi_r;
  logic [25:0] c_lo_r;
  logic [PW-1:0] c_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg_r <= b_neg_r;
      c_hi_r  <= 32'(b_mag_r) * 32'(RadK);
      c_lo_r  <= 26'(b_mag_r) * 26'(RadR) + 26'(QuarterUnits);
      c_p_r   <= {b_p_r, b_flip_r};
    end
  end

  // Stage D: divide the remainder term by 11520 (shift, then reciprocal
  // multiply for the odd factor) and add the whole part: Q2.30 radians.
  logic        d_v_r;
  logic signed [33:0] d_z_r;
  logic [PW-1:0] d_p_r;
  logic [36:0] d_prod;
  logic [31:0] d_q;

  assign d_prod = 37'(c_lo_r[25:RadShift]) * 37'(RecipOdd);
  assign d_q    = c_hi_r + 32'(d_prod >> RecipShift);

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= c_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_z_r <= c_neg_r ? -$signed({2'b00, d_q}) : $signed({2'b00, d_q});
      d_p_r <= c_p_r;
    end
  end

  // CORDIC chain.
  logic              cv [NS+1];
  logic signed [33:0] cx [NS+1];
  logic signed [33:0] cy [NS+1];
  logic signed [33:0] cz [NS+1];
  logic [PW-1:0]     cp [NS+1];

  assign cv[0] = d_v_r;
  assign cx[0] = $signed({2'b00, GainQ30});
  assign cy[0] = '0;
  assign cz[0] = d_z_r;
  assign cp[0] = d_p_r;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    sam_cordic_stage #(.IDX(g), .PW(PW)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .v_in(cv[g]), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]), .p_in(cp[g]),
      .v_r(cv[g+1]), .x_r(cx[g+1]), .y_r(cy[g+1]), .z_r(cz[g+1]), .p_r(cp[g+1])
    );
  end

  // Stage E: clamp to +-1.0 and undo the half turn.
  logic        e_v_r;
  logic signed [31:0] e_c_r, e_s_r;
  logic [PW-2:0] e_p_r;
  logic signed [33:0] e_c, e_s;

  always_comb begin
    e_c = cx[NS];
    e_s = cy[NS];
    if (e_c > OneQ30) e_c = OneQ30;
    if (e_c < -OneQ30) e_c = -OneQ30;
    if (e_s > OneQ30) e_s = OneQ30;
    if (e_s < -OneQ30) e_s = -OneQ30;
    if (cp[NS][0]) begin
      e_c = -e_c;
      e_s = -e_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= cv[NS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_c_r <= e_c[31:0];
      e_s_r <= e_s[31:0];
      e_p_r <= cp[NS][PW-1:1];
    end
  end

  // Payload field split.
  logic signed [31:0] e_px, e_py, e_ox, e_oy;
  logic signed [15:0] e_sx, e_sy;
  assign {e_px, e_py, e_ox, e_oy, e_sx, e_sy} = e_p_r;

  // Stage F: four scale products (16x32).
  logic        f_v_r;
  logic signed [47:0] f_sxc_r, f_syc_r, f_sxs_r, f_sys_r;
  logic signed [31:0] f_px_r, f_py_r, f_ox_r, f_oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_sxc_r <= 48'(e_sx) * 48'(e_c_r);
      f_syc_r <= 48'(e_sy) * 48'(e_c_r);
      f_sxs_r <= 48'(e_sx) * 48'(e_s_r);
      f_sys_r <= 48'(e_sy) * 48'(e_s_r);
      f_px_r <= e_px; f_py_r <= e_py; f_ox_r <= e_ox; f_oy_r <= e_oy;
    end
  end

  // Stage G: round to Q16.16 (fits in 27 bits).
  logic        g_v_r;
  logic signed [26:0] g_sxc_r, g_syc_r, g_sxs_r, g_sys_r;
  logic signed [31:0] g_px_r, g_py_r, g_ox_r, g_oy_r;
  logic signed [47:0] g_rc;
  assign g_rc = 48'sd2097152;

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= f_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      g_sxc_r <= 27'((f_sxc_r + g_rc) >>> 22);
      g_syc_r <= 27'((f_syc_r + g_rc) >>> 22);
      g_sxs_r <= 27'((f_sxs_r + g_rc) >>> 22);
      g_sys_r <= 27'((f_sys_r + g_rc) >>> 22);
      g_px_r <= f_px_r; g_py_r <= f_py_r; g_ox_r <= f_ox_r; g_oy_r <= f_oy_r;
    end
  end

  // Stage H: origin products (32x27).
  logic        h_v_r;
  logic signed [58:0] h_oxc_r, h_oys_r, h_oxs_r, h_oyc_r;
  logic signed [26:0] h_sxc_r, h_syc_r, h_sxs_r, h_sys_r;
  logic signed [31:0] h_px_r, h_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= g_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      h_oxc_r <= 59'(g_ox_r) * 59'(g_sxc_r);
      h_oys_r <= 59'(g_oy_r) * 59'(g_sys_r);
      h_oxs_r <= 59'(g_ox_r) * 59'(g_sxs_r);
      h_oyc_r <= 59'(g_oy_r) * 59'(g_syc_r);
      h_sxc_r <= g_sxc_r; h_syc_r <= g_syc_r;
      h_sxs_r <= g_sxs_r; h_sys_r <= g_sys_r;
      h_px_r <= g_px_r; h_py_r <= g_py_r;
    end
  end

  // Stage I: sum with position and round to Q16.16.
  logic        i_v_r;
  logic signed [63:0] i_tx_r, i_ty_r;
  logic signed [26:0] i_sxc_r, i_syc_r, i_sxs_r, i_sys_r;
  logic signed [63:0] i_tx, i_ty;

  always_comb begin
    i_tx = -64'(h_oxc_r) - 64'(h_oys_r) + (64'(h_px_r) <<< 16) + 64'sd32768;
    i_ty = 64'(h_oxs_r) - 64'(h_oyc_r) + (64'(h_py_r) <<< 16) + 64'sd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= h_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      i_tx_r <= i_tx >>> 16;
      i_ty_r <= i_ty >>> 16;
      i_sxc_r <= h_sxc_r; i_syc_r <= h_syc_r;
      i_sxs_r <= h_sxs_r; i_sys_r <= h_sys_r;
    end
  end

  // Stage J: saturate into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= i_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_m00 <= sat32(64'(i_sxc_r));
      out_m01 <= sat32(64'(i_sys_r));
      out_m02 <= sat32(i_tx_r);
      out_m10 <= sat32(-64'(i_sxs_r));
      out_m11 <= sat32(64'(i_syc_r));
      out_m12 <= sat32(i_ty_r);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sam_cordic_stage.sv =====
// One registered CORDIC rotation stage with its pass-along payload.
`default_nettype none
module sam_cordic_stage
  import sam_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  wire              v_in,
  input  wire signed [33:0] x_in,
  input  wire signed [33:0] y_in,
  input  wire signed [33:0] z_in,
  input  wire [PW-1:0]     p_in,
  output logic             v_r,
  output logic signed [33:0] x_r,
  output logic signed [33:0] y_r,
  output logic signed [33:0] z_r,
  output logic [PW-1:0]    p_r
);
  logic signed [33:0] dx, dy, at;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;
  assign at = {4'd0, atan_q30(5'(IDX))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  // Hold payload on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_in;
      if (!z_in[33]) begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - at;
      end else begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + at;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sam_checker.sv =====
// Port checker for the sprite affine matrix builder, bound to the top level.
`default_nettype none
module sam_checker (
  input wire clk,
  input wire rst_n,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire [31:0] out_m00,
  input wire [31:0] out_m02
);
  // Backpressure only when a result is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without held result");

  // A stalled result stays.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_m00) && $stable(out_m02)))
    else $error("stalled result changed");

  // Stall passes straight through to the input side.
  a_stall_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while output stalled");

  // No result right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind sprite_affine_matrix_builder sam_checker u_sam_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_m00(out_m00), .out_m02(out_m02)
);
`default_nettype wire

// ===== test/sprite_affine_matrix_builder_checker.sv =====
// Checker for the sprite affine matrix builder: predicts matrices and compares them.
`timescale 1ns / 100ps
module sprite_affine_matrix_builder_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [31:0] in_pos_x,
  input  wire signed [31:0] in_pos_y,
  input  wire signed [31:0] in_origin_x,
  input  wire signed [31:0] in_origin_y,
  input  wire signed [15:0] in_scale_x,
  input  wire signed [15:0] in_scale_y,
  input  wire signed [15:0] in_rotation_deg,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [31:0] out_m00,
  input  wire signed [31:0] out_m01,
  input  wire signed [31:0] out_m02,
  input  wire signed [31:0] out_m10,
  input  wire signed [31:0] out_m11,
  input  wire signed [31:0] out_m12,
  output int                fail_count,
  output int                matrices_pending,
  output int                matrices_seen
);

  typedef struct packed {
    logic signed [31:0] m00, m01, m02, m10, m11, m12;
  } affine_t;

  localparam int NumStages = 16;
  localparam longint Turn = 23040, Half = 11520, Quarter = 5760;
  localparam longint PiQ30 = 64'd3373259426, UnitQ30 = 64'd1073741824;
  localparam longint GainQ30 = 64'd652032874;

  longint atan_tbl [24] = '{843314856, 497837829, 263043837, 133525158,
    67021687, 33543516, 16775851, 8388437, 4194282, 2097149, 1048575,
    524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023,
    511, 255, 127};

  affine_t matrix_q[$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > UnitQ30) return UnitQ30;
    if (v < -UnitQ30) return -UnitQ30;
    return v;
  endfunction

  function automatic affine_t build_matrix(longint px, longint py, longint ox,
                                           longint oy, longint sx, longint sy,
                                           longint rot);
    longint r, t, mag, z, x, y, dx, dy, sxc, syc, sxs, sys, tx, ty;
    bit flip;
    affine_t m;
    r = rot % Turn;
    if (r < 0) r += Turn;
    t = -r;
    flip = 0;
    if (t < -Half) t += Turn;
    if (t > Quarter) begin
      t -= Half;
      flip = 1;
    end else if (t < -Quarter) begin
      t += Half;
      flip = 1;
    end
    mag = (t < 0) ? -t : t;
    mag = (mag * PiQ30 + Quarter) / Half;
    z = (t < 0) ? -mag : mag;
    x = GainQ30;
    y = 0;
    for (int i = 0; i < NumStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    x = clip_unit(x);
    y = clip_unit(y);
    if (flip) begin
      x = -x; y = -y;
    end
    sxc = rnd_shift(sx * x, 22);
    syc = rnd_shift(sy * x, 22);
    sxs = rnd_shift(sx * y, 22);
    sys = rnd_shift(sy * y, 22);
    tx = -(ox * sxc) - (oy * sys) + px * 65536;
    ty = (ox * sxs) - (oy * syc) + py * 65536;
    m.m00 = clip32(sxc);
    m.m01 = clip32(sys);
    m.m02 = clip32(rnd_shift(tx, 16));
    m.m10 = clip32(-sxs);
    m.m11 = clip32(syc);
    m.m12 = clip32(rnd_shift(ty, 16));
    return m;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH %s at %0t", what, $time);
    fail_count++;
  endtask

  task automatic check_field(string what, logic signed [31:0] got,
                             logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d expected %0d", what, got, want));
  endtask

  initial begin
    fail_count = 0;
    matrices_seen = 0;
    matrices_pending = 0;
  end

  always @(posedge clk) begin
    affine_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        matrix_q.push_back(build_matrix(in_pos_x, in_pos_y, in_origin_x, in_origin_y,
                                        in_scale_x, in_scale_y, in_rotation_deg));
      if (out_valid && !out_stall) begin
        matrices_seen++;
        if (matrix_q.size() == 0) begin
          report_mismatch("unexpected result");
        end else begin
          want = matrix_q.pop_front();
          check_field("m00", out_m00, want.m00);
          check_field("m01", out_m01, want.m01);
          check_field("m02", out_m02, want.m02);
          check_field("m10", out_m10, want.m10);
          check_field("m11", out_m11, want.m11);
          check_field("m12", out_m12, want.m12);
        end
      end
    end
    matrices_pending <= matrix_q.size();
  end

endmodule

// ===== test/sprite_affine_matrix_builder_tb.sv =====
// Testbench top: stimulus, receiver stalls and verdict for the matrix builder.
`timescale 1ns / 100ps
module sprite_affine_matrix_builder_tb;

  localparam int RandomRequests = 1050;
  localparam int WatchdogLimit  = 3000;
  localparam int DrainCycles    = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_origin_x = '0, in_origin_y = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0, in_rotation_deg = '0;
  wire in_stall, out_valid;
  wire signed [31:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  int fail_count, matrices_pending, matrices_seen;
  int requests_sent = 0;
  int idle_cycles = 0;
  bit calm_stretch = 0;   // no idling on either side while set
  bit holdoff_done = 0;

  always #5 clk = ~clk;

  sprite_affine_matrix_builder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y),
    .in_rotation_deg(in_rotation_deg),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12)
  );

  sprite_affine_matrix_builder_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y),
    .in_rotation_deg(in_rotation_deg),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .fail_count(fail_count), .matrices_pending(matrices_pending),
    .matrices_seen(matrices_seen)
  );

  // Offer one request; sometimes idle for a random gap first, then hold it until accepted.
  task automatic send_request(logic [31:0] px, logic [31:0] py, logic [31:0] ox,
                              logic [31:0] oy, logic [15:0] sx, logic [15:0] sy,
                              logic [15:0] rot);
    int gap;
    gap = 0;
    if (!calm_stretch && $urandom_range(99) < 30) gap = $urandom_range(2, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_scale_x <= sx;
    in_scale_y <= sy;
    in_rotation_deg <= rot;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Pick a coordinate: mostly moderate values, sometimes the full range.
  function automatic logic [31:0] pick_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(32'h01ff_ffff)) - 32'sh00ff_ffff);
  endfunction

  function automatic logic [15:0] pick_scale();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed(16'($urandom_range(2047))) - 16'sd1024);
  endfunction

  // Receiver: random stalls, one long hold-off once the pipe has traffic.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!holdoff_done && requests_sent > 100) begin
        holdoff_done = 1;
        out_stall <= 1'b1;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (calm_stretch) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results pending", matrices_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [15:0] angles [16];
    int settle;
    angles = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, -16'sd11520, 16'sd23040,
               16'sd23039, 16'sd2880, 16'sd17280, 16'sd32767, 16'h8000,
               16'sd5761, 16'sd5759, -16'sd23040, 16'sd1, -16'sd1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: special angles with unit scale and a simple origin.
    foreach (angles[i])
      send_request(32'h0001_0000 * i, -32'sh0002_0000, 32'h0008_0000, 32'h0004_0000,
                   16'h0100, 16'h0100, angles[i]);
    // Field extremes: saturating scale, origin and position.
    send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                 16'h7fff, 16'h8000, 16'sd0);
    send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 16'h8000, 16'h7fff, 16'sd11520);
    send_request(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'sd2880);
    send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 16'hffff, 16'hffff, 16'hffff);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 16'h8000, 16'h8000, 16'sd5760);

    // Random part with a calm stretch in the middle.
    for (int n = 0; n < RandomRequests; n++) begin
      calm_stretch = (n >= 400 && n < 600);
      send_request(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_scale(), pick_scale(), 16'($urandom));
    end
    calm_stretch = 0;
    in_valid <= 1'b0;

    // Drain the pipe, then let it settle.
    while (matrices_pending != 0) @(posedge clk);
    for (settle = 0; settle < DrainCycles; settle++) @(posedge clk);

    $display("covered %0d requests and %0d matrices, incl. full-range fields,",
             requests_sent, matrices_seen);
    $display("all rotation quadrants, random stalls and a long output hold-off");
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
